// ===== design/fgcp_pkg.sv =====
// ----------------------------------------------------------------------------
// fgcp_pkg: shared constants and types for the flagged group chunk packer
// Group geometry, overflow headroom and the chunk store request bundle.
// ----------------------------------------------------------------------------
package fgcp_pkg;

  localparam int unsigned GroupSize  = 8;
  localparam int unsigned ChunkDepth = 8;
  localparam int unsigned ChunkAw    = $clog2(ChunkDepth);
  localparam int unsigned FillW      = 4;
  localparam int unsigned Headroom   = 33;

  localparam logic [31:0] LimitReset = 32'hFFFF_FFFF;

  // Command codes on the input channel
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdFlush = 1'b1;

  // Request from the controller to the chunk store
  typedef struct packed {
    logic               we;
    logic [ChunkAw-1:0] waddr;
    logic [31:0]        wdata;
    logic               re;
    logic [ChunkAw-1:0] raddr;
  } ram_req_t;

endpackage

// ===== design/fgcp_in_if.sv =====
// ----------------------------------------------------------------------------
// fgcp_in_if: chunk input channel
// Valid/ready channel carrying one command with its chunk.
// ----------------------------------------------------------------------------
interface fgcp_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] chunk_value;
  logic        short_chunk;

  modport source (output valid, command, chunk_value, short_chunk, input ready);
  modport sink   (input valid, command, chunk_value, short_chunk, output ready);
endinterface

// ===== design/fgcp_out_if.sv =====
// ----------------------------------------------------------------------------
// fgcp_out_if: byte output channel
// Valid/ready channel carrying one packed byte with its buffer offset.
// ----------------------------------------------------------------------------
interface fgcp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [31:0] out_offset;
  logic        group_end;
  logic        overflow;

  modport source (output valid, out_byte, out_offset, group_end, overflow, input ready);
  modport sink   (input valid, out_byte, out_offset, group_end, overflow, output ready);
endinterface

// ===== design/fgcp_chunk_ram.sv =====
// ----------------------------------------------------------------------------
// fgcp_chunk_ram: chunk store
// One write port, one read port, registered read data held when not reading.
// ----------------------------------------------------------------------------
module fgcp_chunk_ram
  import fgcp_pkg::*;
(
  input  logic        clk_i,
  input  ram_req_t    req_i,
  output logic [31:0] rdata_o
);

  logic [31:0] mem_q [ChunkDepth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fgcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// fgcp_ctrl: group controller and byte emitter
// Fills the chunk store, runs the limit check and streams the group out.
// ----------------------------------------------------------------------------
module fgcp_ctrl
  import fgcp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [31:0]  limit_i,
  fgcp_in_if.sink      in_i,
  fgcp_out_if.source   out_o,
  output ram_req_t     ram_req_o,
  input  logic [31:0]  ram_rdata_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_OVF   = 5'b00100,
    S_MODE  = 5'b01000,
    S_BYTE  = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [7:0]         mode_q, mode_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [31:0]        woff_q, woff_d;
  logic [ChunkAw-1:0] cidx_q, cidx_d;
  logic [1:0]         bidx_q, bidx_d;

  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic [31:0] oo_q, oo_d;
  logic        oe_q, oe_d;
  logic        of_q, of_d;

  logic        slot_free, in_fire;
  logic [32:0] chk_sum;
  logic        no_room, cur_short, last_byte, last_chunk;
  logic [ChunkAw-1:0] slot;

  assign slot_free  = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign chk_sum    = {1'b0, woff_q} + 33'(Headroom);
  assign no_room    = chk_sum > {1'b0, limit_i};
  assign slot       = fill_q[ChunkAw-1:0];
  // mode bits fill from the top, so chunk c sits at bit 7 - c
  assign cur_short  = mode_q[~cidx_q];
  assign last_byte  = cur_short ? (bidx_q == 2'd1) : (bidx_q == 2'd3);
  assign last_chunk = (FillW'(cidx_q) + FillW'(1)) == fill_q;

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    fill_d    = fill_q;
    woff_d    = woff_q;
    cidx_d    = cidx_q;
    bidx_d    = bidx_q;
    ov_d      = ov_q && !out_o.ready;
    ob_d      = ob_q;
    oo_d      = oo_q;
    oe_d      = oe_q;
    of_d      = of_q;
    ram_req_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.command == CmdFlush) begin
            if (fill_q != '0) begin
              state_d = S_CHECK;
            end
          end else if (fill_q >= FillW'(GroupSize)) begin
            state_d = S_OVF;  // group stuck after a failed emit
          end else begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = slot;
            ram_req_o.wdata = in_i.short_chunk ? {16'h0, in_i.chunk_value[15:0]}
                                               : in_i.chunk_value;
            if (in_i.short_chunk) begin
              mode_d = mode_q | (8'h80 >> slot);
            end
            fill_d = fill_q + FillW'(1);
            if (fill_q + FillW'(1) >= FillW'(GroupSize)) begin
              state_d = S_CHECK;
            end
          end
        end
      end
      S_CHECK: begin
        state_d = no_room ? S_OVF : S_MODE;
      end
      S_OVF: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          ob_d    = 8'h00;
          oo_d    = woff_q;
          oe_d    = 1'b1;
          of_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_MODE: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          ob_d    = mode_q;
          oo_d    = woff_q;
          oe_d    = 1'b0;
          of_d    = 1'b0;
          woff_d  = woff_q + 32'd1;
          cidx_d  = '0;
          bidx_d  = '0;
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = '0;
          state_d = S_BYTE;
        end
      end
      S_BYTE: begin
        if (slot_free) begin
          ov_d   = 1'b1;
          ob_d   = ram_rdata_i[8*bidx_q +: 8];
          oo_d   = woff_q;
          of_d   = 1'b0;
          oe_d   = last_byte && last_chunk;
          woff_d = woff_q + 32'd1;
          bidx_d = bidx_q + 2'd1;
          if (last_byte) begin
            bidx_d = '0;
            if (last_chunk) begin
              mode_d  = '0;
              fill_d  = '0;
              state_d = S_IDLE;
            end else begin
              // fetch the next chunk; data lands as this beat is loaded
              cidx_d          = cidx_q + ChunkAw'(1);
              ram_req_o.re    = 1'b1;
              ram_req_o.raddr = cidx_q + ChunkAw'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= '0;
      fill_q  <= '0;
      woff_q  <= '0;
      cidx_q  <= '0;
      bidx_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      fill_q  <= fill_d;
      woff_q  <= woff_d;
      cidx_q  <= cidx_d;
      bidx_q  <= bidx_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
    oo_q <= oo_d;
    oe_q <= oe_d;
    of_q <= of_d;
  end

  assign out_o.valid      = ov_q;
  assign out_o.out_byte   = ob_q;
  assign out_o.out_offset = oo_q;
  assign out_o.group_end  = oe_q;
  assign out_o.overflow   = of_q;

  // Assertions
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(GroupSize))
    else $error("fill count beyond group size");

  a_byte_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BYTE) |-> (fill_q != '0) && (FillW'(cidx_q) < fill_q))
    else $error("chunk index outside the filled group");

  a_ovf_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && of_q) |-> (oe_q && ob_q == 8'h00))
    else $error("overflow beat not a lone zero end beat");

  a_woff_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BYTE && slot_free) |=> woff_q == $past(woff_q) + 32'd1)
    else $error("write offset did not advance by one byte");

endmodule

// ===== design/flagged_group_chunk_packer_top.sv =====
// ----------------------------------------------------------------------------
// flagged_group_chunk_packer_top: chunk group packer
// Gathers 16/32-bit chunks in groups of eight behind a mode byte and
// streams them out little-endian, one byte per beat, with buffer offsets.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents                                  handshake
//  --------  ---  ---------------------------------------------  ----------
//  in_i      in   command, chunk_value, short_chunk              valid/ready
//  out_o     out  out_byte, out_offset, group_end, overflow      valid/ready
//  cfg       in   cfg_wdata_i -> out_limit                       cfg_we_i
//
//  A write beat that does not close a group goes straight into the chunk
//  store. A closing write or a flush of a non-empty group is accepted and
//  the limit check runs; then one output beat per cycle follows unless the
//  output stalls (mode byte plus 2 or 4 per chunk, up to 33), or a lone
//  zero overflow beat if the check fails. Input is refused while a group
//  is being streamed; output stalls hold the emitter. Reset clears the
//  group, the write offset and sets out_limit to all ones; the chunk store
//  needs no clearing since only filled slots are ever read.
// ----------------------------------------------------------------------------
module flagged_group_chunk_packer_top
  import fgcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  fgcp_in_if.sink     in_i,
  fgcp_out_if.source  out_o
);

  // out_limit: capacity used by the headroom check
  logic [31:0] limit_q, limit_d;
  ram_req_t    ram_req;
  logic [31:0] ram_rdata;

  assign limit_d = cfg_we_i ? cfg_wdata_i : limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else begin
      limit_q <= limit_d;
    end
  end

  // Controller: fills the store, checks room, sequences the byte stream
  fgcp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit_q),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // Chunk store: one slot per chunk of the open group
  fgcp_chunk_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

endmodule
